// ===== design/assert_macros.svh =====
// Assertion macros shared by the tone sequencer RTL.
// Uses the clock and reset names of the module that includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define STNS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define STNS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/stns_pkg.sv =====
// Package of the square-wave tone sequencer: word types, codes and constants.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package stns_pkg;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_LOAD  = 2'd1,
      OP_START = 2'd2,
      OP_STOP  = 2'd3
   } stns_op_type;

   localparam int unsigned CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TICK_RATE    = 3'd0,
      CSR_SPEED        = 3'd1,
      CSR_AMP_PERCENT  = 3'd2,
      CSR_FULL_SCALE   = 3'd3,
      CSR_NOTE_COUNT   = 3'd4,
      CSR_REPEAT_COUNT = 3'd5
   } stns_csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_AMP_MUL,
      ST_AMP_DIV,
      ST_NOTE_RD,
      ST_DUR_MUL,
      ST_DUR_DIV,
      ST_TCK_MUL,
      ST_TCK_DIV,
      ST_STEP_MUL,
      ST_STEP_DIV,
      ST_PH_ADD,
      ST_PH_WRAP,
      ST_PH_OUT,
      ST_RESULT
   } stns_state_type;

   typedef struct packed {
      stns_op_type opcode;
      logic [3:0]  note_slot;
      logic [15:0] note_freq_hz;
      logic [15:0] note_duration_ms;
   } stns_req_type;

   typedef struct packed {
      logic signed [16:0] drive_value;
      logic               playing;
   } stns_rsp_type;

   typedef struct packed {
      logic        start;
      logic [31:0] mcand;
      logic [15:0] mplier;
      logic [31:0] addend;
   } stns_mul_cmd_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } stns_mul_sts_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [15:0] divisor;
   } stns_div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } stns_div_sts_type;

   localparam int unsigned MUL_STEPS = 16;
   localparam int unsigned MUL_CNT_W = 5;
   localparam int unsigned DIV_STEPS = 32;
   localparam int unsigned DIV_CNT_W = 6;

   localparam logic [31:0] PHASE_SCALE = 32'd1000000;
   localparam logic [31:0] PHASE_HALF  = 32'd500000;
   localparam logic [15:0] MS_PER_S    = 16'd1000;
   localparam logic [31:0] ROUND_UP_MS = 32'd999;
   localparam logic [7:0]  PCT_LIMIT   = 8'd20;
   localparam logic [15:0] PCT_FULL    = 16'd100;

   localparam logic [15:0] TICK_RATE_RST  = 16'd1000;
   localparam logic [15:0] SPEED_RST      = 16'd1000;
   localparam logic [15:0] FULL_SCALE_RST = 16'd32767;
   localparam logic [15:0] REPEAT_RST     = 16'd1;

endpackage

// ===== design/stns_mul.sv =====
// Bit-serial shift-and-add multiplier: addend + mcand * mplier, modulo 2^32.
// Depends on stns_pkg; one multiplier bit per cycle.
`timescale 1ns / 1ps

module stns_mul
   import stns_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  stns_mul_cmd_type cmd,
   output stns_mul_sts_type sts
);

   logic [31:0]          acc_ff;
   logic [31:0]          mcand_ff;
   logic [15:0]          mplier_ff;
   logic [MUL_CNT_W-1:0] cnt_ff;
   logic                 done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            cnt_ff <= MUL_CNT_W'(MUL_STEPS);
         end else if (cnt_ff != '0) begin
            cnt_ff  <= cnt_ff - 1'b1;
            done_ff <= (cnt_ff == MUL_CNT_W'(1));
         end
      end
   end

   // The multiplicand shifts left and drops its top bits, which keeps the
   // product modulo 2^32.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         acc_ff    <= cmd.addend;
         mcand_ff  <= cmd.mcand;
         mplier_ff <= cmd.mplier;
      end else if (cnt_ff != '0) begin
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff  <= {mcand_ff[30:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[15:1]};
      end
   end

   assign sts.done   = done_ff;
   assign sts.result = acc_ff;

endmodule

// ===== design/stns_div.sv =====
// Restoring divider, one quotient bit per cycle: 32-bit dividend, 16-bit divisor.
// Depends on stns_pkg. The divisor is never zero here.
`timescale 1ns / 1ps

module stns_div
   import stns_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  stns_div_cmd_type cmd,
   output stns_div_sts_type sts
);

   logic [31:0]          quo_ff;
   logic [15:0]          rem_ff;
   logic [15:0]          dvs_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 done_ff;
   logic [16:0]          shifted;
   logic [16:0]          diff;
   logic                 fits;

   // The dividend sits in the quotient register and leaves it from the top
   // while quotient bits enter at the bottom.
   assign shifted = {rem_ff, quo_ff[31]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = (shifted >= {1'b0, dvs_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            cnt_ff <= DIV_CNT_W'(DIV_STEPS);
         end else if (cnt_ff != '0) begin
            cnt_ff  <= cnt_ff - 1'b1;
            done_ff <= (cnt_ff == DIV_CNT_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         quo_ff <= cmd.dividend;
         rem_ff <= '0;
         dvs_ff <= cmd.divisor;
      end else if (cnt_ff != '0) begin
         rem_ff <= fits ? diff[15:0] : shifted[15:0];
         quo_ff <= {quo_ff[30:0], fits};
      end
   end

   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

endmodule

// ===== design/square_tone_note_sequencer_core.sv =====
// Top level of the square-wave tone sequencer: control, note table and play state.
// Depends on stns_pkg, stns_mul, stns_div and assert_macros.svh.
//
//   Port group  Direction  Handshake          Word
//   req_        in         req_valid/ready    stns_req_type (opcode, slot, freq, duration)
//   rsp_        out        rsp_valid/ready    stns_rsp_type (drive_value, playing)
//   csr_        in         csr_we only        csr_index, csr_wdata (16 bits)
//
// Load, stop, an ignored start and a non-playing tick go from decode to the result. A tick
// inside a note adds the phase step, wraps it and sets the drive (a silent note skips both);
// a note change first reads the note and runs the duration, tick and step multiply/divide
// steps; a start runs the amplitude steps before those and skips the phase. The result is
// valid as req_ready rises again; a result still waiting in the output register stalls the
// next one. Synchronous reset clears control and play registers, not payload or note table.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module square_tone_note_sequencer_core
   import stns_pkg::*;
#(
   parameter int unsigned NOTE_SLOTS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  stns_req_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output stns_rsp_type         rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata
);

   localparam int unsigned IDX_W      = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
   localparam logic [8:0]  SLOTS_WIDE = 9'(NOTE_SLOTS);

   // Configuration registers.
   logic [15:0] tick_rate_ff;
   logic [15:0] speed_ff;
   logic [7:0]  pct_ff;
   logic [15:0] full_scale_ff;
   logic [4:0]  count_ff;
   logic [15:0] repeat_ff;

   // Play state.
   stns_state_type     state_ff;
   stns_state_type     state_in;
   stns_req_type       req_ff;
   logic               launch_ff;
   logic               playing_ff;
   logic [4:0]         cur_ff;
   logic [4:0]         play_count_ff;
   logic [15:0]        play_speed_ff;
   logic [15:0]        repeats_ff;
   logic [31:0]        elapsed_ff;
   logic [31:0]        dur_ticks_ff;
   logic [31:0]        acc_ff;
   logic [31:0]        inc_ff;
   logic [15:0]        amp_ff;
   logic [31:0]        scaled_ff;
   logic [31:0]        sum_ff;
   logic signed [16:0] drive_ff;
   logic [31:0]        entry_ff;
   logic               rsp_valid_ff;
   stns_rsp_type       rsp_data_ff;

   logic [31:0] note_mem [NOTE_SLOTS];

   // Derived values.
   logic [15:0]      rate_now;
   logic [15:0]      speed_eff;
   logic [4:0]       pct_clamp;
   logic [8:0]       count_wide;
   logic [4:0]       count_lim;
   logic [8:0]       slot_wide;
   logic [8:0]       cur_wide;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] rd_addr;
   logic             slot_ok;
   logic [5:0]       next_cur;
   logic             seq_wrap;
   logic             more_repeats;
   logic             note_due;
   logic             start_ok;
   logic             do_idle;
   logic             emit;
   logic             ready_int;
   logic             in_mul_state;
   logic [16:0]      amp_pos;

   stns_mul_cmd_type mul_cmd;
   stns_mul_sts_type mul_sts;
   stns_div_cmd_type div_cmd;
   stns_div_sts_type div_sts;

   stns_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .sts   (mul_sts)
   );

   stns_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .sts   (div_sts)
   );

   assign rate_now   = (tick_rate_ff == '0) ? MS_PER_S : tick_rate_ff;
   assign speed_eff  = (play_speed_ff == '0) ? MS_PER_S : play_speed_ff;
   assign pct_clamp  = (pct_ff > PCT_LIMIT) ? PCT_LIMIT[4:0] : pct_ff[4:0];
   assign count_wide = {4'b0, count_ff};
   assign count_lim  = (count_wide > SLOTS_WIDE) ? SLOTS_WIDE[4:0] : count_ff;
   assign slot_wide  = {5'b0, req_ff.note_slot};
   assign cur_wide   = {4'b0, cur_ff};
   assign wr_addr    = slot_wide[IDX_W-1:0];
   assign rd_addr    = cur_wide[IDX_W-1:0];
   assign slot_ok    = (slot_wide < SLOTS_WIDE);

   assign next_cur     = {1'b0, cur_ff} + 6'd1;
   assign seq_wrap     = (next_cur >= {1'b0, play_count_ff});
   assign more_repeats = (repeats_ff > 16'd1);
   assign note_due     = (elapsed_ff >= dur_ticks_ff);
   assign start_ok     = (count_ff != '0) && (repeat_ff != '0);
   assign amp_pos      = {1'b0, amp_ff};

   // A stop, or a tick that runs out of notes and repeats, returns to idle.
   assign do_idle = (state_ff == ST_DECODE) &&
                    ((req_ff.opcode == OP_STOP) ||
                     ((req_ff.opcode == OP_TICK) && playing_ff && note_due &&
                      seq_wrap && !more_repeats));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            unique case (req_ff.opcode)
               OP_LOAD, OP_STOP: state_in = ST_RESULT;
               OP_START: state_in = start_ok ? ST_AMP_MUL : ST_RESULT;
               OP_TICK: begin
                  priority if (!playing_ff) state_in = ST_RESULT;
                  else if (note_due) begin
                     state_in = (seq_wrap && !more_repeats) ? ST_RESULT : ST_NOTE_RD;
                  end
                  else state_in = ST_PH_ADD;
               end
            endcase
         end
         ST_AMP_MUL:  if (mul_sts.done) state_in = ST_AMP_DIV;
         ST_AMP_DIV:  if (div_sts.done) state_in = ST_NOTE_RD;
         ST_NOTE_RD:  state_in = ST_DUR_MUL;
         ST_DUR_MUL:  if (mul_sts.done) state_in = ST_DUR_DIV;
         ST_DUR_DIV:  if (div_sts.done) state_in = ST_TCK_MUL;
         ST_TCK_MUL:  if (mul_sts.done) state_in = ST_TCK_DIV;
         ST_TCK_DIV:  if (div_sts.done) state_in = ST_STEP_MUL;
         ST_STEP_MUL: if (mul_sts.done) state_in = ST_STEP_DIV;
         ST_STEP_DIV: begin
            if (div_sts.done) begin
               state_in = (req_ff.opcode == OP_TICK) ? ST_PH_ADD : ST_RESULT;
            end
         end
         ST_PH_ADD:  state_in = (inc_ff == '0) ? ST_RESULT : ST_PH_WRAP;
         ST_PH_WRAP: state_in = ST_PH_OUT;
         ST_PH_OUT:  state_in = ST_RESULT;
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs: handshake and arithmetic unit commands.
   always_comb begin
      ready_int      = (state_ff == ST_IDLE);
      emit           = (state_ff == ST_RESULT) && (!rsp_valid_ff || rsp_ready);
      in_mul_state   = 1'b0;
      mul_cmd.mcand  = '0;
      mul_cmd.mplier = '0;
      mul_cmd.addend = '0;
      div_cmd.divisor = PCT_FULL;
      unique case (state_ff)
         ST_AMP_MUL: begin
            in_mul_state   = 1'b1;
            mul_cmd.mcand  = {16'b0, full_scale_ff};
            mul_cmd.mplier = {11'b0, pct_clamp};
         end
         ST_DUR_MUL: begin
            in_mul_state   = 1'b1;
            mul_cmd.mcand  = {16'b0, MS_PER_S};
            mul_cmd.mplier = entry_ff[31:16];
            mul_cmd.addend = {17'b0, speed_eff[15:1]};
         end
         ST_TCK_MUL: begin
            in_mul_state   = 1'b1;
            mul_cmd.mcand  = scaled_ff;
            mul_cmd.mplier = rate_now;
            mul_cmd.addend = ROUND_UP_MS;
         end
         ST_STEP_MUL: begin
            in_mul_state   = 1'b1;
            mul_cmd.mcand  = PHASE_SCALE;
            mul_cmd.mplier = entry_ff[15:0];
            mul_cmd.addend = {17'b0, rate_now[15:1]};
         end
         ST_DUR_DIV:  div_cmd.divisor = speed_eff;
         ST_TCK_DIV:  div_cmd.divisor = MS_PER_S;
         ST_STEP_DIV: div_cmd.divisor = rate_now;
         default: div_cmd.divisor = PCT_FULL;
      endcase
      mul_cmd.start    = launch_ff && in_mul_state;
      div_cmd.start    = launch_ff && ((state_ff == ST_AMP_DIV) || (state_ff == ST_DUR_DIV) ||
                                       (state_ff == ST_TCK_DIV) || (state_ff == ST_STEP_DIV));
      div_cmd.dividend = mul_sts.result;
   end

   assign req_ready = ready_int;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Control, configuration and play state.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_rate_ff  <= TICK_RATE_RST;
         speed_ff      <= SPEED_RST;
         pct_ff        <= '0;
         full_scale_ff <= FULL_SCALE_RST;
         count_ff      <= '0;
         repeat_ff     <= REPEAT_RST;
         state_ff      <= ST_IDLE;
         launch_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         playing_ff    <= 1'b0;
         cur_ff        <= '0;
         play_count_ff <= '0;
         play_speed_ff <= MS_PER_S;
         repeats_ff    <= '0;
         elapsed_ff    <= '0;
         dur_ticks_ff  <= '0;
         acc_ff        <= '0;
         inc_ff        <= '0;
         amp_ff        <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_TICK_RATE:    tick_rate_ff  <= csr_wdata;
               CSR_SPEED:        speed_ff      <= csr_wdata;
               CSR_AMP_PERCENT:  pct_ff        <= csr_wdata[7:0];
               CSR_FULL_SCALE:   full_scale_ff <= csr_wdata;
               CSR_NOTE_COUNT:   count_ff      <= csr_wdata[4:0];
               CSR_REPEAT_COUNT: repeat_ff     <= csr_wdata;
               default: ;
            endcase
         end

         state_ff  <= state_in;
         launch_ff <= (state_in != state_ff);

         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (do_idle) begin
            playing_ff    <= 1'b0;
            cur_ff        <= '0;
            play_count_ff <= '0;
            play_speed_ff <= MS_PER_S;
            repeats_ff    <= '0;
            elapsed_ff    <= '0;
            dur_ticks_ff  <= '0;
            acc_ff        <= '0;
            inc_ff        <= '0;
            amp_ff        <= '0;
         end else begin
            unique case (state_ff)
               ST_DECODE: begin
                  if ((req_ff.opcode == OP_START) && start_ok) begin
                     playing_ff    <= 1'b1;
                     play_count_ff <= count_lim;
                     play_speed_ff <= speed_ff;
                     cur_ff        <= '0;
                     repeats_ff    <= repeat_ff;
                  end else if ((req_ff.opcode == OP_TICK) && playing_ff && note_due) begin
                     if (seq_wrap) begin
                        repeats_ff <= repeats_ff - 16'd1;
                        cur_ff     <= '0;
                     end else begin
                        cur_ff <= next_cur[4:0];
                     end
                  end
               end
               ST_AMP_DIV: begin
                  if (div_sts.done) amp_ff <= div_sts.quotient[15:0];
               end
               ST_TCK_DIV: begin
                  if (div_sts.done) begin
                     dur_ticks_ff <= (div_sts.quotient == '0) ? 32'd1 : div_sts.quotient;
                     elapsed_ff   <= '0;
                     acc_ff       <= '0;
                  end
               end
               ST_STEP_DIV: begin
                  if (div_sts.done) inc_ff <= div_sts.quotient;
               end
               ST_PH_ADD: begin
                  elapsed_ff <= elapsed_ff + 32'd1;
               end
               ST_PH_WRAP: begin
                  // Wraps once only: a step of a full cycle or more can leave
                  // the accumulator at or above the scale.
                  acc_ff <= (sum_ff >= PHASE_SCALE) ? (sum_ff - PHASE_SCALE) : sum_ff;
               end
               default: ;
            endcase
         end
      end
   end

   // Working payload registers.
   always_ff @(posedge clock) begin
      if (ready_int && req_valid) begin
         req_ff <= req_data;
      end
      if (state_ff == ST_DECODE) begin
         drive_ff <= '0;
      end
      if ((state_ff == ST_DUR_DIV) && div_sts.done) begin
         scaled_ff <= (div_sts.quotient == '0) ? 32'd1 : div_sts.quotient;
      end
      if (state_ff == ST_PH_ADD) begin
         sum_ff <= acc_ff + inc_ff;
      end
      if (state_ff == ST_PH_OUT) begin
         drive_ff <= (acc_ff < PHASE_HALF) ? amp_pos : (17'd0 - amp_pos);
      end
      if (emit) begin
         rsp_data_ff.drive_value <= drive_ff;
         rsp_data_ff.playing     <= playing_ff;
      end
   end

   // Note table: frequency in the low half of a word, duration in the high half.
   always_ff @(posedge clock) begin
      if ((state_ff == ST_DECODE) && (req_ff.opcode == OP_LOAD) && slot_ok) begin
         note_mem[wr_addr] <= {req_ff.note_duration_ms, req_ff.note_freq_hz};
      end
      entry_ff <= note_mem[rd_addr];
   end

   `STNS_ASSERT_NOW(a_play_state_sane,
      (state_ff == ST_IDLE) && playing_ff,
      (cur_ff < play_count_ff) && (dur_ticks_ff != '0),
      "playing with a note index past the count or a zero duration")

   `STNS_ASSERT_NOW(a_mul_done_in_mul_state,
      mul_sts.done,
      in_mul_state,
      "multiplier finished outside a multiply step")

   `STNS_ASSERT_NEXT(a_start_sets_playing,
      (state_ff == ST_DECODE) && (req_ff.opcode == OP_START) && start_ok,
      playing_ff,
      "accepted start did not begin playback")

   `STNS_ASSERT_NOW(a_drive_only_while_playing,
      rsp_valid_ff && (rsp_data_ff.drive_value != '0),
      rsp_data_ff.playing,
      "nonzero drive word while not playing")

endmodule
